@@ rtl/crc_pkg.sv @@
package crc_pkg;

    // Default build parameters
    localparam int MAX_SIDE_DEF      = 256;
    localparam int FRACTION_BITS_DEF = 8;

    // Field widths of the input and result items
    localparam int CMD_W        = 2;
    localparam int CENTER_W     = 20;
    localparam int RADIUS_W     = 19;
    localparam int BYTE_W       = 8;
    localparam int READ_COORD_W = 8;

    // Input tdata layout, lowest bit first
    localparam int CX_LSB     = 0;
    localparam int CY_LSB     = CX_LSB + CENTER_W;
    localparam int RAD_LSB    = CY_LSB + CENTER_W;
    localparam int FILL_BIT   = RAD_LSB + RADIUS_W;
    localparam int PAINT_LSB  = FILL_BIT + 1;
    localparam int RCOL_LSB   = PAINT_LSB + BYTE_W;
    localparam int RROW_LSB   = RCOL_LSB + READ_COORD_W;
    localparam int IN_USED_W  = RROW_LSB + READ_COORD_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Result layout
    localparam int OUT_TDATA_W = BYTE_W;
    localparam int OUT_TUSER_W = 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration registers
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_SIDE_W  = 9;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd2;

    localparam logic [CFG_SIDE_W-1:0] WIDTH_RESET      = 9'd1;
    localparam logic [CFG_SIDE_W-1:0] HEIGHT_RESET     = 9'd1;
    localparam logic [BYTE_W-1:0]     BACKGROUND_RESET = 8'd32;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic calc_limits;
        logic sweep_start;
        logic sweep_clear;
        logic sweep_step;
        logic read_issue;
        logic load_result;
    } crc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             sweep_last;
        logic             pipe_empty;
        logic             out_free;
    } crc_sts_t;

endpackage

@@ rtl/circle_raster_canvas.sv @@
// Byte canvas with a circle rasteriser. Items are taken one at a time. A clear
// command sweeps the whole canvas memory through its single write port, one
// cell a cycle, writing all 2^(2*ceil(log2(MAX_SIDE))) cells (65536 at the
// default size). A draw command visits each cell of the canvas_width by
// canvas_height region once, one pixel a cycle through a squared-distance
// pipeline (differences, squares, sum) feeding that same write port. A read
// goes through the registered memory read; an unused command code goes
// straight to the result step. The next item is accepted while a result
// still waits in the output register. The canvas is not cleared after reset;
// its contents are undefined until the first clear.
module circle_raster_canvas
    import crc_pkg::*;
#(
    parameter int MAX_SIDE      = MAX_SIDE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // center_x[19:0], center_y[39:20], radius[58:40], filled[59],
    // paint_byte[67:60], read_column[75:68], read_row[83:76], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cell_byte[7:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // is_read_result[0]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    crc_cmd_t cmd;
    crc_sts_t sts;

    crc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crc_datapath #(
        .MAX_SIDE      (MAX_SIDE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ rtl/crc_ram.sv @@
module crc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/crc_ctrl.sv @@
module crc_ctrl
    import crc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  crc_sts_t sts,
    output crc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SWEEP    = 3'd2;
    localparam logic [2:0] ST_DRAIN    = 3'd3;
    localparam logic [2:0] ST_RESULT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (sts.command)
                    CMD_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_clear = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    CMD_DRAW:
                    begin
                        cmd.calc_limits = 1'b1;
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    CMD_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/crc_datapath.sv @@
module crc_datapath
    import crc_pkg::*;
#(
    parameter int MAX_SIDE      = MAX_SIDE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]       s_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,
    input  crc_cmd_t               cmd,
    output crc_sts_t               sts
);

    localparam int COORD_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int CL_W     = (SIDE_W > CFG_SIDE_W) ? SIDE_W : CFG_SIDE_W;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int PIX_W    = COORD_W + FRACTION_BITS;
    localparam int DIFF_W   = ((PIX_W + 1 > CENTER_W) ? PIX_W + 1 : CENTER_W) + 1;
    localparam int MAG_W    = DIFF_W - 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int D2_W     = SQ_W + 1;
    localparam int LIM_W    = 2 * RADIUS_W;
    localparam int CMP_W    = (D2_W > LIM_W) ? D2_W : LIM_W;
    localparam int RD_EXT_W = COORD_W + READ_COORD_W;
    localparam int RG_W     = SIDE_W + READ_COORD_W;

    // Side clamped to 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
        logic [CL_W-1:0] ve;
        ve = CL_W'(v);
        if (ve == '0)
        begin
            return SIDE_W'(1);
        end
        if (ve > CL_W'(MAX_SIDE))
        begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(ve);
    endfunction

    // Configuration registers
    logic [CFG_SIDE_W-1:0] width_reg;
    logic [CFG_SIDE_W-1:0] height_reg;
    logic [BYTE_W-1:0]     bg_reg;

    // Latched item
    logic [CMD_W-1:0]           cmd_code_reg;
    logic signed [CENTER_W-1:0] cx_reg;
    logic signed [CENTER_W-1:0] cy_reg;
    logic [RADIUS_W-1:0]        rad_reg;
    logic                       filled_reg;
    logic [BYTE_W-1:0]          paint_reg;
    logic [READ_COORD_W-1:0]    rcol_reg;
    logic [READ_COORD_W-1:0]    rrow_reg;

    // Limits
    logic [LIM_W-1:0] on_lim_reg;
    logic [LIM_W-1:0] in_lim_reg;
    logic             has_inner_reg;

    // Sweep counters
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic               clear_reg;

    // Distance pipeline
    logic              p1_valid_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [MAG_W-1:0]  dx_reg;
    logic [MAG_W-1:0]  dy_reg;
    logic              p2_valid_reg;
    logic [ADDR_W-1:0] p2_addr_reg;
    logic [SQ_W-1:0]   dx2_reg;
    logic [SQ_W-1:0]   dy2_reg;
    logic              p3_valid_reg;
    logic [ADDR_W-1:0] p3_addr_reg;
    logic [D2_W-1:0]   d2_reg;

    // Result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_isread_reg;

    logic [SIDE_W-1:0]  w_side;
    logic [SIDE_W-1:0]  h_side;
    logic [SIDE_W-1:0]  w_m1;
    logic [SIDE_W-1:0]  h_m1;
    logic [COORD_W-1:0] lim_col;
    logic [COORD_W-1:0] lim_row;
    logic               sweep_last;

    logic [RADIUS_W-1:0] one_r;
    logic                has_inner_c;
    logic [RADIUS_W-1:0] r_m1;

    logic [PIX_W-1:0]         pix_x;
    logic [PIX_W-1:0]         pix_y;
    logic signed [DIFF_W-1:0] px_s;
    logic signed [DIFF_W-1:0] py_s;
    logic signed [DIFF_W-1:0] cx_s;
    logic signed [DIFF_W-1:0] cy_s;
    logic [MAG_W-1:0]         dx_mag;
    logic [MAG_W-1:0]         dy_mag;

    logic [CMP_W-1:0] d2_e;
    logic             on_pix;
    logic             inner_pix;
    logic             paint_wr;
    logic             clear_wr;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [BYTE_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    logic [RD_EXT_W-1:0] rcol_ext;
    logic [RD_EXT_W-1:0] rrow_ext;
    logic                in_region;
    logic                is_rd;
    logic                out_free;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            bg_reg     <= BACKGROUND_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:      width_reg  <= cfg_data;
                REG_HEIGHT:     height_reg <= cfg_data;
                REG_BACKGROUND: bg_reg     <= cfg_data[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_code_reg <= s_tuser;
            cx_reg       <= s_tdata[CX_LSB +: CENTER_W];
            cy_reg       <= s_tdata[CY_LSB +: CENTER_W];
            rad_reg      <= s_tdata[RAD_LSB +: RADIUS_W];
            filled_reg   <= s_tdata[FILL_BIT];
            paint_reg    <= s_tdata[PAINT_LSB +: BYTE_W];
            rcol_reg     <= s_tdata[RCOL_LSB +: READ_COORD_W];
            rrow_reg     <= s_tdata[RROW_LSB +: READ_COORD_W];
        end
    end

    // Squared radius limits for the border test
    assign one_r       = RADIUS_W'(1'b1) << FRACTION_BITS;
    assign has_inner_c = rad_reg >= one_r;
    assign r_m1        = rad_reg - one_r;

    always_ff @(posedge clk)
    begin
        if (cmd.calc_limits)
        begin
            on_lim_reg    <= LIM_W'(rad_reg) * LIM_W'(rad_reg);
            in_lim_reg    <= has_inner_c ? LIM_W'(r_m1) * LIM_W'(r_m1) : '0;
            has_inner_reg <= has_inner_c;
        end
    end

    // Sweep bounds: full array for clear, region in use for draw
    assign w_side     = clamp_side(width_reg);
    assign h_side     = clamp_side(height_reg);
    assign w_m1       = w_side - SIDE_W'(1);
    assign h_m1       = h_side - SIDE_W'(1);
    assign lim_col    = clear_reg ? '1 : w_m1[COORD_W-1:0];
    assign lim_row    = clear_reg ? '1 : h_m1[COORD_W-1:0];
    assign sweep_last = (col_reg == lim_col) && (row_reg == lim_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            clear_reg <= 1'b0;
        end
        else if (cmd.sweep_start)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            clear_reg <= cmd.sweep_clear;
        end
        else if (cmd.sweep_step)
        begin
            if (col_reg == lim_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + COORD_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COORD_W'(1);
            end
        end
    end

    // Stage 1: distance along each axis
    assign pix_x  = PIX_W'(col_reg) << FRACTION_BITS;
    assign pix_y  = PIX_W'(row_reg) << FRACTION_BITS;
    assign px_s   = $signed(DIFF_W'(pix_x));
    assign py_s   = $signed(DIFF_W'(pix_y));
    assign cx_s   = DIFF_W'(cx_reg);
    assign cy_s   = DIFF_W'(cy_reg);
    assign dx_mag = (px_s >= cx_s) ? MAG_W'(px_s - cx_s) : MAG_W'(cx_s - px_s);
    assign dy_mag = (py_s >= cy_s) ? MAG_W'(py_s - cy_s) : MAG_W'(cy_s - py_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.sweep_step && !clear_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // Stages 1 to 3: differences, squares, sum
    always_ff @(posedge clk)
    begin
        p1_addr_reg <= {row_reg, col_reg};
        dx_reg      <= dx_mag;
        dy_reg      <= dy_mag;
        p2_addr_reg <= p1_addr_reg;
        dx2_reg     <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        dy2_reg     <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        p3_addr_reg <= p2_addr_reg;
        d2_reg      <= D2_W'(dx2_reg) + D2_W'(dy2_reg);
    end

    // Paint decision
    assign d2_e      = CMP_W'(d2_reg);
    assign on_pix    = d2_e <= CMP_W'(on_lim_reg);
    assign inner_pix = has_inner_reg && (d2_e <= CMP_W'(in_lim_reg));
    assign paint_wr  = p3_valid_reg && on_pix && (filled_reg || !inner_pix);
    assign clear_wr  = cmd.sweep_step && clear_reg;

    // Canvas write port shared by clear and draw
    assign ram_wr_en   = clear_wr || paint_wr;
    assign ram_wr_addr = clear_reg ? {row_reg, col_reg} : p3_addr_reg;
    assign ram_wr_data = clear_reg ? bg_reg : paint_reg;

    // Read address and region check
    assign rcol_ext    = RD_EXT_W'(rcol_reg);
    assign rrow_ext    = RD_EXT_W'(rrow_reg);
    assign ram_rd_addr = {rrow_ext[COORD_W-1:0], rcol_ext[COORD_W-1:0]};
    assign in_region   = (RG_W'(rcol_reg) < RG_W'(w_side)) &&
                         (RG_W'(rrow_reg) < RG_W'(h_side));
    assign is_rd       = (cmd_code_reg == CMD_READ) && in_region;

    crc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.read_issue),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_byte_reg   <= is_rd ? ram_rd_data : '0;
            out_isread_reg <= is_rd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_isread_reg;

    assign sts.command    = cmd_code_reg;
    assign sts.sweep_last = sweep_last;
    assign sts.pipe_empty = !p1_valid_reg && !p2_valid_reg && !p3_valid_reg;
    assign sts.out_free   = out_free;

`ifndef NO_ASSERTIONS
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("result load did not raise output valid");

    a_no_pixel_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> !clear_reg)
        else $error("draw pixel in flight during clear sweep");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_isread_reg) |-> (out_byte_reg == '0))
        else $error("non-read result carries a nonzero byte");
`endif

endmodule
